[sv/pac_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pac_pkg: polygon area and centroid shared definitions
// Payload types, field widths, status codes and controller/datapath links.
// ----------------------------------------------------------------------------
package pac_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int COORD_BITS   = 16;

    localparam int CNT_W     = $clog2(MAX_VERTICES + 2);
    localparam int PROD_W    = 2 * COORD_BITS;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int SUM_W     = COORD_BITS + 1;
    localparam int WPROD_W   = CROSS_W + SUM_W;
    localparam int ACC_W     = 64;
    localparam int AREA_W    = 34;
    localparam int CEN_W     = 24;
    localparam int CEN_FRAC  = 8;
    localparam int STATUS_W  = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_AREA = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic                         last_vertex;
    } pac_in_t;

    typedef struct packed {
        logic signed [AREA_W-1:0]   area_doubled;
        logic signed [CEN_W-1:0]    centroid_x;
        logic signed [CEN_W-1:0]    centroid_y;
        logic        [STATUS_W-1:0] status;
    } pac_out_t;

    typedef struct packed {
        logic load_vertex;
        logic closing;
        logic edge_mul;
        logic edge_cross;
        logic edge_wmul;
        logic edge_acc;
        logic fin_area;
        logic fin_abs;
        logic div_start;
        logic div_sel_y;
        logic out_load;
    } pac_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic count_over;
        logic area_zero;
        logic div_done;
        logic out_free;
    } pac_stat_t;

endpackage
`default_nettype wire

[sv/polygon_area_centroid.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// polygon_area_centroid: shoelace area and centroid of one polygon
// Top level: controller, datapath and output register.
// ----------------------------------------------------------------------------
// Vertices arrive one per transfer in boundary order; last_vertex closes the
// polygon and yields one result (doubled signed area, centroid with 8
// fraction bits, status). A vertex that forms an edge is followed by the
// edge steps (cross-product multipliers, subtract, weight multipliers,
// 64-bit accumulate); the first vertex and vertices past the limit get
// none. The last vertex adds its own edge, the closing edge, the final
// scaling and two divisions (one quotient bit per cycle in a shared
// divider) before the result transfer; overflow or zero area cut this short.
// A waiting result sits in the output register while the next polygon's
// vertices are taken.
// ----------------------------------------------------------------------------
module polygon_area_centroid (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pac_pkg::pac_in_t   in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output pac_pkg::pac_out_t       out_data
);
    import pac_pkg::*;

    pac_cmd_t  cmd;
    pac_stat_t stat;

    pac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (in_data.last_vertex),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    pac_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

[sv/pac_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pac_div: centroid divider
// Restoring divider, one quotient bit per cycle: |s| * 2^8 / |d|, signed,
// saturated to the centroid width.
// ----------------------------------------------------------------------------
module pac_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [pac_pkg::ACC_W-1:0]  dividend,
    input  wire logic        [pac_pkg::ACC_W-1:0]  divisor,
    input  wire logic                              divisor_neg,
    output logic                                   done,
    output logic signed      [pac_pkg::CEN_W-1:0]  quotient
);
    import pac_pkg::*;

    localparam int STEP_W = $clog2(CEN_W);
    localparam int HI_SH  = CEN_W - CEN_FRAC;

    typedef enum logic [1:0] {D_IDLE, D_PREP, D_RUN, D_FIN} state_t;

    state_t                  state_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    done_reg;
    logic [ACC_W-1:0]        mag_reg;
    logic [ACC_W-1:0]        den_reg;
    logic [ACC_W-1:0]        rem_reg;
    logic [CEN_W-1:0]        low_reg;
    logic [CEN_W-1:0]        q_reg;
    logic                    neg_reg;
    logic                    sat_reg;
    logic signed [CEN_W-1:0] quot_reg;

    logic [ACC_W-1:0]        hi;
    logic [ACC_W:0]          trial;
    logic [ACC_W:0]          diff;
    logic                    fits;
    logic signed [CEN_W-1:0] quot_next;

    always_comb
    begin
        hi    = ACC_W'(mag_reg[ACC_W-1:HI_SH]);
        trial = {rem_reg, low_reg[CEN_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = trial >= {1'b0, den_reg};
        if (neg_reg)
        begin
            if (sat_reg || (q_reg[CEN_W-1] && (|q_reg[CEN_W-2:0])))
                quot_next = {1'b1, {(CEN_W-1){1'b0}}};
            else
                quot_next = -q_reg;
        end
        else
        begin
            if (sat_reg || q_reg[CEN_W-1])
                quot_next = {1'b0, {(CEN_W-1){1'b1}}};
            else
                quot_next = q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                        state_reg <= D_PREP;
                end
                D_PREP:
                begin
                    step_reg <= '0;
                    if (hi >= den_reg)
                        state_reg <= D_FIN;
                    else
                        state_reg <= D_RUN;
                end
                D_RUN:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(CEN_W - 1))
                        state_reg <= D_FIN;
                end
                D_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    mag_reg <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
                    neg_reg <= dividend[ACC_W-1] ^ divisor_neg;
                    den_reg <= divisor;
                end
            end
            D_PREP:
            begin
                sat_reg <= hi >= den_reg;
                rem_reg <= hi;
                low_reg <= {mag_reg[HI_SH-1:0], {CEN_FRAC{1'b0}}};
                q_reg   <= '0;
            end
            D_RUN:
            begin
                rem_reg <= fits ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
                q_reg   <= {q_reg[CEN_W-2:0], fits};
                low_reg <= {low_reg[CEN_W-2:0], 1'b0};
            end
            D_FIN:
            begin
                quot_reg <= quot_next;
            end
            default:
            begin
                quot_reg <= quot_reg;
            end
        endcase
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
`default_nettype wire

[sv/pac_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pac_dp: polygon area and centroid datapath
// Vertex registers, edge multipliers, 64-bit sums, final scaling, divider
// and output register.
// ----------------------------------------------------------------------------
module pac_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pac_pkg::pac_cmd_t  cmd,
    output pac_pkg::pac_stat_t      stat,
    input  wire pac_pkg::pac_in_t   in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output pac_pkg::pac_out_t       out_data
);
    import pac_pkg::*;

    logic [CNT_W-1:0]               cnt_reg;
    logic signed [ACC_W-1:0]        area_sum_reg;
    logic signed [ACC_W-1:0]        csum_x_reg;
    logic signed [ACC_W-1:0]        csum_y_reg;
    logic                           out_valid_reg;

    logic signed [COORD_BITS-1:0]   first_x_reg, first_y_reg;
    logic signed [COORD_BITS-1:0]   prev_x_reg, prev_y_reg;
    logic signed [COORD_BITS-1:0]   cur_x_reg, cur_y_reg;
    logic signed [PROD_W-1:0]       p1_reg, p2_reg;
    logic signed [SUM_W-1:0]        sx_reg, sy_reg;
    logic signed [CROSS_W-1:0]      c_reg;
    logic signed [WPROD_W-1:0]      wx_reg, wy_reg;
    logic signed [ACC_W-1:0]        d_reg;
    logic [ACC_W-1:0]               ad_reg;
    logic                           dneg_reg;
    logic                           area_zero_reg;
    logic signed [AREA_W-1:0]       area_sat_reg;
    logic signed [CEN_W-1:0]        cen_x_reg;
    pac_out_t                       out_reg;

    logic signed [COORD_BITS-1:0]   b_x, b_y;
    logic [ACC_W-AREA_W:0]          area_top;
    logic signed [AREA_W-1:0]       area_sat;
    logic                           div_done;
    logic signed [CEN_W-1:0]        div_q;
    pac_out_t                       out_next;

    always_comb
    begin
        b_x = cmd.closing ? first_x_reg : cur_x_reg;
        b_y = cmd.closing ? first_y_reg : cur_y_reg;

        area_top = area_sum_reg[ACC_W-1:AREA_W-1];
        if ((&area_top) || !(|area_top))
            area_sat = area_sum_reg[AREA_W-1:0];
        else if (area_sum_reg[ACC_W-1])
            area_sat = {1'b1, {(AREA_W-1){1'b0}}};
        else
            area_sat = {1'b0, {(AREA_W-1){1'b1}}};

        out_next = '0;
        if (cnt_reg > CNT_W'(MAX_VERTICES))
            out_next.status = STATUS_OVERFLOW;
        else if (area_zero_reg)
            out_next.status = STATUS_ZERO_AREA;
        else
        begin
            out_next.status       = STATUS_OK;
            out_next.area_doubled = area_sat_reg;
            out_next.centroid_x   = cen_x_reg;
            out_next.centroid_y   = div_q;
        end
    end

    pac_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (cmd.div_start),
        .dividend    (cmd.div_sel_y ? csum_y_reg : csum_x_reg),
        .divisor     (ad_reg),
        .divisor_neg (dneg_reg),
        .done        (div_done),
        .quotient    (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            area_sum_reg  <= '0;
            csum_x_reg    <= '0;
            csum_y_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_vertex)
            begin
                if (cnt_reg == '0)
                    cnt_reg <= CNT_W'(1);
                else if (cnt_reg < CNT_W'(MAX_VERTICES))
                    cnt_reg <= cnt_reg + CNT_W'(1);
                else
                    cnt_reg <= CNT_W'(MAX_VERTICES + 1);
            end
            if (cmd.edge_wmul)
                area_sum_reg <= area_sum_reg + ACC_W'(c_reg);
            if (cmd.edge_acc)
            begin
                csum_x_reg <= csum_x_reg + ACC_W'(wx_reg);
                csum_y_reg <= csum_y_reg + ACC_W'(wy_reg);
            end
            if (cmd.out_load)
            begin
                cnt_reg       <= '0;
                area_sum_reg  <= '0;
                csum_x_reg    <= '0;
                csum_y_reg    <= '0;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_vertex)
        begin
            if (cnt_reg == '0)
            begin
                first_x_reg <= in_data.vertex_x;
                first_y_reg <= in_data.vertex_y;
                prev_x_reg  <= in_data.vertex_x;
                prev_y_reg  <= in_data.vertex_y;
            end
            cur_x_reg <= in_data.vertex_x;
            cur_y_reg <= in_data.vertex_y;
        end
        if (cmd.edge_mul)
        begin
            p1_reg <= PROD_W'(prev_x_reg) * PROD_W'(b_y);
            p2_reg <= PROD_W'(b_x) * PROD_W'(prev_y_reg);
            sx_reg <= SUM_W'(prev_x_reg) + SUM_W'(b_x);
            sy_reg <= SUM_W'(prev_y_reg) + SUM_W'(b_y);
        end
        if (cmd.edge_cross)
            c_reg <= CROSS_W'(p1_reg) - CROSS_W'(p2_reg);
        if (cmd.edge_wmul)
        begin
            wx_reg <= WPROD_W'(c_reg) * WPROD_W'(sx_reg);
            wy_reg <= WPROD_W'(c_reg) * WPROD_W'(sy_reg);
            if (!cmd.closing)
            begin
                prev_x_reg <= cur_x_reg;
                prev_y_reg <= cur_y_reg;
            end
        end
        if (cmd.fin_area)
        begin
            d_reg         <= area_sum_reg + (area_sum_reg <<< 1);
            area_zero_reg <= area_sum_reg == '0;
            area_sat_reg  <= area_sat;
        end
        if (cmd.fin_abs)
        begin
            ad_reg   <= d_reg[ACC_W-1] ? ACC_W'(-d_reg) : ACC_W'(d_reg);
            dneg_reg <= d_reg[ACC_W-1];
        end
        if (div_done && !cmd.div_sel_y)
            cen_x_reg <= div_q;
        if (cmd.out_load)
            out_reg <= out_next;
    end

    always_comb
    begin
        stat.count_zero = cnt_reg == '0;
        stat.count_full = cnt_reg >= CNT_W'(MAX_VERTICES);
        stat.count_over = cnt_reg > CNT_W'(MAX_VERTICES);
        stat.area_zero  = area_zero_reg;
        stat.div_done   = div_done;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

[sv/pac_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pac_ctrl: polygon area and centroid controller
// Sequences vertex load, edge steps, closing edge, final scaling, the two
// divisions and the output transfer.
// ----------------------------------------------------------------------------
module pac_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_last,
    output logic                     in_ready,
    output pac_pkg::pac_cmd_t        cmd,
    input  wire pac_pkg::pac_stat_t  stat
);
    import pac_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_CROSS, S_WMUL, S_ACC, S_CLOSE, S_AREA, S_ABS,
        S_DIVX, S_WAITX, S_DIVY, S_WAITY, S_OUT
    } state_t;

    state_t state_reg;
    logic   last_reg;
    logic   closing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            last_reg    <= 1'b0;
            closing_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        last_reg    <= in_last;
                        closing_reg <= 1'b0;
                        if (!stat.count_zero && !stat.count_full)
                            state_reg <= S_MUL;
                        else if (in_last)
                            state_reg <= S_CLOSE;
                    end
                end
                S_MUL:   state_reg <= S_CROSS;
                S_CROSS: state_reg <= S_WMUL;
                S_WMUL:  state_reg <= S_ACC;
                S_ACC:
                begin
                    if (closing_reg)
                        state_reg <= S_AREA;
                    else if (last_reg)
                        state_reg <= S_CLOSE;
                    else
                        state_reg <= S_IDLE;
                end
                S_CLOSE:
                begin
                    if (stat.count_over)
                        state_reg <= S_OUT;
                    else
                    begin
                        closing_reg <= 1'b1;
                        state_reg   <= S_MUL;
                    end
                end
                S_AREA: state_reg <= S_ABS;
                S_ABS:
                begin
                    if (stat.area_zero)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_DIVX;
                end
                S_DIVX: state_reg <= S_WAITX;
                S_WAITX:
                begin
                    if (stat.div_done)
                        state_reg <= S_DIVY;
                end
                S_DIVY: state_reg <= S_WAITY;
                S_WAITY:
                begin
                    if (stat.div_done)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (stat.out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd             = '0;
        cmd.closing     = closing_reg;
        cmd.load_vertex = (state_reg == S_IDLE) && in_valid;
        cmd.edge_mul    = state_reg == S_MUL;
        cmd.edge_cross  = state_reg == S_CROSS;
        cmd.edge_wmul   = state_reg == S_WMUL;
        cmd.edge_acc    = state_reg == S_ACC;
        cmd.fin_area    = state_reg == S_AREA;
        cmd.fin_abs     = state_reg == S_ABS;
        cmd.div_start   = (state_reg == S_DIVX) || (state_reg == S_DIVY);
        cmd.div_sel_y   = (state_reg == S_DIVY) || (state_reg == S_WAITY);
        cmd.out_load    = (state_reg == S_OUT) && stat.out_free;
    end

    assign in_ready = state_reg == S_IDLE;

endmodule
`default_nettype wire
